/* design/yrgb_pkg.sv */
`timescale 1ns / 1ps

package yrgb_pkg;

    localparam int NUM_W  = 21;
    localparam int QUO_W  = 18;
    localparam int RCP_W  = 19;
    localparam int PROD_W = QUO_W + RCP_W;
    localparam int SHIFT  = 28;

    localparam logic signed [NUM_W-1:0] COEF_LUMA   = 21'sd1164;
    localparam logic signed [NUM_W-1:0] COEF_RV     = 21'sd1596;
    localparam logic signed [NUM_W-1:0] COEF_GU     = 21'sd391;
    localparam logic signed [NUM_W-1:0] COEF_GV     = 21'sd813;
    localparam logic signed [NUM_W-1:0] COEF_BU     = 21'sd2018;
    localparam logic signed [8:0]       CHROMA_BIAS = 9'sd128;
    localparam logic signed [8:0]       LUMA_BIAS   = 9'sd16;
    localparam logic [7:0]              CHAN_MAX    = 8'd255;

    // Every numerator at or above 255 * 1000 saturates the channel.
    localparam logic signed [NUM_W-1:0] SAT_LIMIT = 21'sd255000;

    // Ceiling of 2^28 / 1000; floor(n * RECIP / 2^28) equals n / 1000 for
    // every n below the saturation limit.
    localparam logic [RCP_W-1:0] RECIP = 19'd268436;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end_in;
    } yuyv_beat_t;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       frame_end_out;
    } rgb_beat_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] red_first;
        logic signed [NUM_W-1:0] green_first;
        logic signed [NUM_W-1:0] blue_first;
        logic signed [NUM_W-1:0] red_second;
        logic signed [NUM_W-1:0] green_second;
        logic signed [NUM_W-1:0] blue_second;
        logic                    frame_end;
    } numer_t;

    function automatic logic [7:0] scale_channel(input logic signed [NUM_W-1:0] numer);
        logic [PROD_W-1:0] prod;
        logic [7:0]        chan;
        prod = PROD_W'(numer[QUO_W-1:0]) * PROD_W'(RECIP);
        if (numer < 0)
        begin
            chan = 8'd0;
        end
        else if (numer >= SAT_LIMIT)
        begin
            chan = CHAN_MAX;
        end
        else
        begin
            chan = prod[SHIFT+7:SHIFT];
        end
        return chan;
    endfunction

endpackage

/* design/yrgb_numer.sv */
`timescale 1ns / 1ps

module yrgb_numer
    import yrgb_pkg::*;
(
    input  yuyv_beat_t beat,
    output numer_t     numer
);

    logic signed [8:0]       y0_off;
    logic signed [8:0]       y1_off;
    logic signed [8:0]       cb_off;
    logic signed [8:0]       cr_off;
    logic signed [NUM_W-1:0] lum0;
    logic signed [NUM_W-1:0] lum1;
    logic signed [NUM_W-1:0] red_term;
    logic signed [NUM_W-1:0] green_term;
    logic signed [NUM_W-1:0] blue_term;

    always_comb
    begin
        y0_off = $signed({1'b0, beat.luma_first}) - LUMA_BIAS;
        y1_off = $signed({1'b0, beat.luma_second}) - LUMA_BIAS;
        cb_off = $signed({1'b0, beat.chroma_blue}) - CHROMA_BIAS;
        cr_off = $signed({1'b0, beat.chroma_red}) - CHROMA_BIAS;

        lum0       = COEF_LUMA * NUM_W'(y0_off);
        lum1       = COEF_LUMA * NUM_W'(y1_off);
        red_term   = COEF_RV * NUM_W'(cr_off);
        green_term = COEF_GU * NUM_W'(cb_off) + COEF_GV * NUM_W'(cr_off);
        blue_term  = COEF_BU * NUM_W'(cb_off);

        numer.red_first    = lum0 + red_term;
        numer.green_first  = lum0 - green_term;
        numer.blue_first   = lum0 + blue_term;
        numer.red_second   = lum1 + red_term;
        numer.green_second = lum1 - green_term;
        numer.blue_second  = lum1 + blue_term;
        numer.frame_end    = beat.frame_end_in;
    end

endmodule

/* design/yrgb_scale.sv */
`timescale 1ns / 1ps

module yrgb_scale
    import yrgb_pkg::*;
(
    input  numer_t    numer,
    output rgb_beat_t rgb
);

    always_comb
    begin
        rgb.red_first     = scale_channel(numer.red_first);
        rgb.green_first   = scale_channel(numer.green_first);
        rgb.blue_first    = scale_channel(numer.blue_first);
        rgb.red_second    = scale_channel(numer.red_second);
        rgb.green_second  = scale_channel(numer.green_second);
        rgb.blue_second   = scale_channel(numer.blue_second);
        rgb.frame_end_out = numer.frame_end;
    end

endmodule

/* design/yuyv_to_rgb_converter.sv */
`timescale 1ns / 1ps

// YUYV 4:2:2 to RGB888 converter with BT.601 integer coefficients.
// The pix channel carries one YUYV group per beat: two luma samples that
// share one blue-difference and one red-difference chroma sample, plus an
// end-of-frame flag. The rgb channel returns one beat per group with two
// RGB888 pixels, each channel clamped to 0..255, and the flag copied.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The datapath is three registers deep: an input register,
// a register holding the six channel numerators, and the result register.
// rgb valid rises once an accepted pix beat has been loaded in turn into the
// input, numerator and result registers, and the block accepts one group
// every cycle while the receiver keeps stall low.
// The rate is set by the three register stages, each of which advances
// whenever the stage after it is empty or moving.
// When the receiver stalls, the result register holds its beat and the
// earlier stages keep filling; pix_stall rises only once all three stages
// hold a beat. Reset clears the stage valid flags, so no rgb beat is shown
// until a new group has been accepted.
module yuyv_to_rgb_converter
    import yrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    output logic       pix_stall,
    input  yuyv_beat_t pix_data,
    output logic       rgb_valid,
    input  logic       rgb_stall,
    output rgb_beat_t  rgb_data
);

    logic       in_valid_reg;
    logic       in_valid_next;
    yuyv_beat_t in_data_reg;
    logic       mid_valid_reg;
    logic       mid_valid_next;
    numer_t     mid_data_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    rgb_beat_t  out_data_reg;

    logic       out_adv;
    logic       mid_adv;
    logic       in_adv;
    numer_t     numer;
    rgb_beat_t  rgb;

    yrgb_numer u_numer
    (
        .beat  (in_data_reg),
        .numer (numer)
    );

    yrgb_scale u_scale
    (
        .numer (mid_data_reg),
        .rgb   (rgb)
    );

    always_comb
    begin
        out_adv        = !out_valid_reg || !rgb_stall;
        mid_adv        = !mid_valid_reg || out_adv;
        in_adv         = !in_valid_reg || mid_adv;
        in_valid_next  = in_adv ? pix_valid : in_valid_reg;
        mid_valid_next = mid_adv ? in_valid_reg : mid_valid_reg;
        out_valid_next = out_adv ? mid_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && pix_valid)
        begin
            in_data_reg <= pix_data;
        end
        if (mid_adv && in_valid_reg)
        begin
            mid_data_reg <= numer;
        end
        if (out_adv && mid_valid_reg)
        begin
            out_data_reg <= rgb;
        end
    end

    assign pix_stall = !in_adv;
    assign rgb_valid = out_valid_reg;
    assign rgb_data  = out_data_reg;

endmodule

/* design/yrgb_checker.sv */
`timescale 1ns / 1ps

module yrgb_checker
    import yrgb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       pix_valid,
    input logic       pix_stall,
    input logic       rgb_valid,
    input logic       rgb_stall,
    input rgb_beat_t  rgb_data
);

    // A held result beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb_data))
        else $error("rgb beat changed while stalled");

    // With the receiver open, an accepted group shows up as an rgb beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall) ##1 !rgb_stall ##1 !rgb_stall |=> rgb_valid)
        else $error("rgb beat missing three cycles after pix beat");

    // The input side only backs up behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> rgb_valid && rgb_stall)
        else $error("pix stalled without a stalled rgb beat");

    // Reset empties the pipeline.
    assert property (@(posedge clk)
        !rst_n |-> !rgb_valid)
        else $error("rgb valid during reset");

endmodule

bind yuyv_to_rgb_converter yrgb_checker u_yrgb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb_data  (rgb_data)
);
